### hw/rtl/jrdc_pkg.sv
// Shared types, constants and helpers for the journal record deframer/checker.
package jrdc_pkg;

  localparam int unsigned REC_LEN_CAP = 8192;
  localparam int unsigned LEN_W      = 14;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HDR_BYTES  = 12;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [LEN_W-1:0] MAX_LEN_RST  = LEN_W'(REC_LEN_CAP);
  localparam logic [OFF_W-1:0] CAPACITY_RST = OFF_W'(8 * 1024 * 1024);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_BAD_HDR  = 3'd2,
    EV_MISMATCH = 3'd3,
    EV_CAPACITY = 3'd4,
    EV_CLEAN    = 3'd5,
    EV_TRUNC    = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    event_t             event_res;
    logic [7:0]         payload_byte;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   record_length;
  } out_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_len;
    logic [OFF_W-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic      vld;
    out_beat_t beat;
  } eng_res_t;

  // "WAL1"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h57;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h4C;
      2'd3:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/jrdc_cfg.sv
// Configuration registers: record length limit and journal capacity.
module jrdc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [jrdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jrdc_pkg::CFG_W-1:0]       cfg_wdata,
  output jrdc_pkg::cfg_t                   cfg
);
  import jrdc_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic [OFF_W-1:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RST;
      capacity_r <= CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LEN:  max_len_r  <= cfg_wdata[LEN_W-1:0];
        CFG_CAPACITY: capacity_r <= cfg_wdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.max_len  = max_len_r;
  assign cfg.capacity = capacity_r;

endmodule

### hw/rtl/jrdc_in_reg.sv
// Input register stage with stall generation.
module jrdc_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jrdc_pkg::in_beat_t in_beat,
  input  logic               advance,
  output logic               beat_vld,
  output jrdc_pkg::in_beat_t beat
);
  import jrdc_pkg::*;

  logic     vld_r;
  in_beat_t beat_r;
  logic     take;

  assign in_stall = vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

  assign beat_vld = vld_r;
  assign beat     = beat_r;

endmodule

### hw/rtl/jrdc_engine.sv
// Deframing state, header checks, FNV-1a hash and verdict logic.
module jrdc_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  jrdc_pkg::in_beat_t  beat,
  input  jrdc_pkg::cfg_t      cfg,
  output jrdc_pkg::eng_res_t  res,
  output jrdc_pkg::phase_t    phase
);
  import jrdc_pkg::*;

  phase_t           phase_r,    phase_nxt;
  logic [3:0]       hcnt_r,     hcnt_nxt;
  logic             magic_ok_r, magic_ok_nxt;
  logic [31:0]      len_r,      len_nxt;
  logic [31:0]      sum_r,      sum_nxt;
  logic [31:0]      hash_r,     hash_nxt;
  logic [LEN_W-1:0] pcnt_r,     pcnt_nxt;
  logic [OFF_W-1:0] rec_off_r,  rec_off_nxt;
  logic [OFF_W:0]   end_off_r,  end_off_nxt;

  logic [LEN_W-1:0] limit;
  logic [31:0]      hash_step;
  logic [LEN_W-1:0] pcnt_inc;
  logic             hdr_bad;

  assign limit     = (cfg.max_len < MAX_LEN_RST) ? cfg.max_len : MAX_LEN_RST;
  assign hash_step = 32'((hash_r ^ {24'd0, beat.data_byte}) * FNV_PRIME);
  assign pcnt_inc  = pcnt_r + LEN_W'(1);
  assign hdr_bad   = !magic_ok_r || (len_r == 32'd0) ||
                     (len_r > {{(32-LEN_W){1'b0}}, limit});

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    hcnt_nxt     = hcnt_r;
    magic_ok_nxt = magic_ok_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    hash_nxt     = hash_r;
    pcnt_nxt     = pcnt_r;
    rec_off_nxt  = rec_off_r;
    end_off_nxt  = end_off_r;
    case (phase_r)
      PH_HEADER: begin
        if (beat.kind == KIND_EOS) begin
          phase_nxt = PH_HALTED;
        end else begin
          if (hcnt_r < 4'd4) begin
            if (beat.data_byte != magic_byte(hcnt_r[1:0])) magic_ok_nxt = 1'b0;
          end else if (hcnt_r < 4'd8) begin
            len_nxt = {len_r[23:0], beat.data_byte};
          end else begin
            sum_nxt = {sum_r[23:0], beat.data_byte};
          end
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_r == 4'(HDR_BYTES - 1)) begin
            if (hdr_bad) begin
              phase_nxt = PH_HALTED;
            end else begin
              phase_nxt   = PH_PAYLOAD;
              pcnt_nxt    = '0;
              hash_nxt    = FNV_BASIS;
              end_off_nxt = {1'b0, rec_off_r} + (OFF_W+1)'(HDR_BYTES) +
                            (OFF_W+1)'(len_r[LEN_W-1:0]);
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (beat.kind == KIND_EOS) begin
          phase_nxt = PH_HALTED;
        end else begin
          hash_nxt = hash_step;
          pcnt_nxt = pcnt_inc;
          if (pcnt_inc >= len_r[LEN_W-1:0]) begin
            if (hash_step != sum_r || end_off_r > {1'b0, cfg.capacity}) begin
              phase_nxt = PH_HALTED;
            end else begin
              rec_off_nxt  = end_off_r[OFF_W-1:0];
              phase_nxt    = PH_HEADER;
              hcnt_nxt     = '0;
              magic_ok_nxt = 1'b1;
              len_nxt      = '0;
              sum_nxt      = '0;
              hash_nxt     = FNV_BASIS;
              pcnt_nxt     = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res                    = '0;
    res.beat.offset        = rec_off_r;
    res.beat.payload_byte  = beat.data_byte;
    res.beat.record_length = len_r[LEN_W-1:0];
    case (phase_r)
      PH_HEADER: begin
        res.beat.payload_byte  = 8'd0;
        res.beat.record_length = '0;
        if (beat.kind == KIND_EOS) begin
          res.vld            = 1'b1;
          res.beat.event_res = (hcnt_r == 4'd0) ? EV_CLEAN : EV_TRUNC;
        end else if (hcnt_r == 4'(HDR_BYTES - 1) && hdr_bad) begin
          res.vld            = 1'b1;
          res.beat.event_res = EV_BAD_HDR;
        end
      end
      PH_PAYLOAD: begin
        res.vld = 1'b1;
        if (beat.kind == KIND_EOS) begin
          res.beat.event_res    = EV_TRUNC;
          res.beat.payload_byte = 8'd0;
        end else if (pcnt_inc < len_r[LEN_W-1:0]) begin
          res.beat.event_res = EV_PAYLOAD;
        end else if (hash_step != sum_r) begin
          res.beat.event_res = EV_MISMATCH;
        end else if (end_off_r > {1'b0, cfg.capacity}) begin
          res.beat.event_res = EV_CAPACITY;
        end else begin
          res.beat.event_res = EV_ACCEPT;
          res.beat.offset    = end_off_r[OFF_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hcnt_r     <= '0;
      magic_ok_r <= 1'b1;
      len_r      <= '0;
      sum_r      <= '0;
      hash_r     <= FNV_BASIS;
      pcnt_r     <= '0;
      rec_off_r  <= '0;
      end_off_r  <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      magic_ok_r <= magic_ok_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
      hash_r     <= hash_nxt;
      pcnt_r     <= pcnt_nxt;
      rec_off_r  <= rec_off_nxt;
      end_off_r  <= end_off_nxt;
    end
  end

  assign phase = phase_r;

endmodule

### hw/rtl/jrdc_out_reg.sv
// Result register holding one beat until the sink takes it.
module jrdc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                load_vld,
  input  jrdc_pkg::out_beat_t load_beat,
  output logic                out_valid,
  output jrdc_pkg::out_beat_t out_beat
);
  import jrdc_pkg::*;

  logic      vld_r;
  out_beat_t beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= load_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_vld) begin
      beat_r <= load_beat;
    end
  end

  assign out_valid = vld_r;
  assign out_beat  = beat_r;

endmodule

### hw/rtl/journal_record_deframer_checker_core.sv
// Top level of the journal record deframer and FNV-1a checker.
//
//   channel | direction | handshake          | beat
//   in_     | sink      | in_valid/in_stall   | in_beat_t  {kind, data_byte}
//   out_    | source    | out_valid/out_stall | out_beat_t {event_res, payload_byte,
//           |           |                     |             offset, record_length}
//   cfg_    | sink      | cfg_we              | cfg_index, cfg_wdata
//
// One byte per cycle sustained while the result side does not stall; an accepted
// byte passes through the input register, then hash/verdict logic into the result register.
// The FNV step is one constant multiply per byte, so the hash loop sets the pace.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the input stage; beats that give no result still
// wait for a free result register.
module journal_record_deframer_checker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jrdc_pkg::in_beat_t             in_beat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jrdc_pkg::out_beat_t            out_beat,
  input  logic                           cfg_we,
  input  logic [jrdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jrdc_pkg::CFG_W-1:0]     cfg_wdata
);
  import jrdc_pkg::*;

  cfg_t     cfg;
  in_beat_t beat;
  logic     beat_vld;
  logic     advance;
  logic     fire;
  eng_res_t res;
  phase_t   phase;

  assign advance = !out_valid || !out_stall;
  assign fire    = beat_vld && advance;

  jrdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jrdc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .advance  (advance),
    .beat_vld (beat_vld),
    .beat     (beat)
  );

  jrdc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .beat  (beat),
    .cfg   (cfg),
    .res   (res),
    .phase (phase)
  );

  jrdc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .load_vld  (beat_vld && res.vld),
    .load_beat (res.beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (beat_vld && out_valid))
    else $error("input stalled without a pending beat");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.event_res == EV_PAYLOAD) |-> (out_beat.record_length != '0))
    else $error("payload beat with zero record length");

  a_verdict_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.vld && res.beat.event_res != EV_PAYLOAD &&
     res.beat.event_res != EV_ACCEPT) |=> (phase == PH_HALTED))
    else $error("failing verdict did not halt");

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase == PH_HALTED) |-> !res.vld)
    else $error("result produced while halted");
`endif

endmodule

### tb/journal_record_deframer_checker_core_tb.sv
// Self-checking testbench for the journal record deframer and FNV-1a checker core.
`timescale 1ns / 1ps

module journal_record_deframer_checker_core_tb;
  import jrdc_pkg::*;

  localparam logic [31:0]          MAGIC_WORD   = 32'h5741_4C31;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
  localparam int unsigned          LIMIT        = 1_000_000;
  localparam int                   RAND_BEATS   = 500;
  localparam int                   LONG_LEN     = 256;
  localparam int                   DRAIN_CYCLES = 4;
  localparam int                   HOLD_CYCLES  = 300;

  typedef enum int {
    FIN_CLEAN, FIN_CUT_HEADER, FIN_CUT_PAYLOAD, FIN_BAD_MAGIC,
    FIN_ZERO_LEN, FIN_LONG_LEN, FIN_BAD_SUM, FIN_OVER_CAP
  } finale_t;

  string finale_name [0:7] = '{"clean end", "tail cut in a header", "tail cut in a payload",
                               "bad magic", "zero length", "length over limit",
                               "checksum mismatch", "capacity exceeded"};

  class journal_verdicts;
    logic [LEN_W-1:0] max_len;
    logic [OFF_W-1:0] capacity;
    phase_t           ph;
    int               hdr_cnt;
    bit               magic_good;
    logic [31:0]      len_field;
    logic [31:0]      check_word;
    logic [31:0]      hash;
    int               pay_cnt;
    logic [OFF_W-1:0] rec_off;
    out_beat_t        due[$];
    int               errors;
    int               checked;
    int               accepted;

    function new();
      max_len  = MAX_LEN_RST;
      capacity = CAPACITY_RST;
      rec_off  = '0;
      errors   = 0;
      checked  = 0;
      accepted = 0;
      open_record();
    endfunction

    function void open_record();
      ph         = PH_HEADER;
      hdr_cnt    = 0;
      magic_good = 1'b1;
      len_field  = '0;
      check_word = '0;
      hash       = FNV_BASIS;
      pay_cnt    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_MAX_LEN) max_len = data[LEN_W-1:0];
      else if (idx == CFG_CAPACITY) capacity = data[OFF_W-1:0];
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void post(event_t ev, logic [7:0] b, logic [LEN_W-1:0] len);
      out_beat_t e;
      e.event_res     = ev;
      e.payload_byte  = b;
      e.offset        = rec_off;
      e.record_length = len;
      due = {due, e};
    endfunction

    function void take_byte(in_beat_t b);
      int               lim;
      longint unsigned  end_at;
      logic [LEN_W-1:0] done_len;
      if (ph == PH_HALTED) return;
      if (b.kind == KIND_EOS) begin
        if (ph == PH_HEADER && hdr_cnt == 0) post(EV_CLEAN, 8'h00, '0);
        else if (ph == PH_PAYLOAD) post(EV_TRUNC, 8'h00, len_field[LEN_W-1:0]);
        else post(EV_TRUNC, 8'h00, '0);
        ph = PH_HALTED;
        return;
      end
      if (ph == PH_HEADER) begin
        if (hdr_cnt < 4) begin
          if (b.data_byte != MAGIC_WORD[31 - 8*hdr_cnt -: 8]) magic_good = 1'b0;
        end else if (hdr_cnt < 8) begin
          len_field = {len_field[23:0], b.data_byte};
        end else begin
          check_word = {check_word[23:0], b.data_byte};
        end
        hdr_cnt++;
        if (hdr_cnt < HDR_BYTES) return;
        lim = (max_len < REC_LEN_CAP) ? int'(max_len) : int'(REC_LEN_CAP);
        if (!magic_good || len_field == 0 || len_field > 32'(lim)) begin
          post(EV_BAD_HDR, 8'h00, '0);
          ph = PH_HALTED;
        end else begin
          ph      = PH_PAYLOAD;
          pay_cnt = 0;
          hash    = FNV_BASIS;
        end
        return;
      end
      hash = (hash ^ {24'h0, b.data_byte}) * FNV_PRIME;
      pay_cnt++;
      if (32'(pay_cnt) < len_field) begin
        post(EV_PAYLOAD, b.data_byte, len_field[LEN_W-1:0]);
      end else if (hash != check_word) begin
        post(EV_MISMATCH, b.data_byte, len_field[LEN_W-1:0]);
        ph = PH_HALTED;
      end else begin
        end_at = 64'(rec_off) + 64'(HDR_BYTES) + 64'(len_field);
        if (end_at > 64'(capacity)) begin
          post(EV_CAPACITY, b.data_byte, len_field[LEN_W-1:0]);
          ph = PH_HALTED;
        end else begin
          done_len = len_field[LEN_W-1:0];
          rec_off  = end_at[OFF_W-1:0];
          open_record();
          post(EV_ACCEPT, b.data_byte, done_len);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task match_event(out_beat_t got);
      out_beat_t want;
      if (due.size() == 0) begin
        report($sformatf("result with nothing due, event %0d", got.event_res));
        return;
      end
      want = due.pop_front();
      checked++;
      if (want.event_res == EV_ACCEPT) accepted++;
      if (got.event_res !== want.event_res)
        report($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte %0h, want %0h", got.payload_byte, want.payload_byte));
      if (got.offset !== want.offset)
        report($sformatf("offset %0d, want %0d", got.offset, want.offset));
      if (got.record_length !== want.record_length)
        report($sformatf("record_length %0d, want %0d", got.record_length,
                         want.record_length));
    endtask

    task close();
      if (due.size() != 0) report($sformatf("%0d results never arrived", due.size()));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_beat;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_beat;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  journal_verdicts sb;
  bit              in_idle_on;
  bit              out_idle_on;
  bit              hold_req;
  int              beats_in;
  int              cfg_writes;
  int unsigned     cycles = 0;

  journal_record_deframer_checker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("journal_record_deframer_checker_core_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_byte(in_beat);
      if (out_valid && !out_stall) sb.match_event(out_beat);
    end
  end

  // result side back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        gap = $urandom_range(1, 9);
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_beat_t make_beat(logic kind, logic [7:0] b);
    in_beat_t r;
    r.kind      = kind;
    r.data_byte = b;
    return r;
  endfunction

  function automatic int cur_limit();
    return (sb.max_len < REC_LEN_CAP) ? int'(sb.max_len) : int'(REC_LEN_CAP);
  endfunction

  function automatic int pick_len();
    int top;
    int len;
    top = (cur_limit() < 48) ? cur_limit() : 48;
    len = $urandom_range(1, top);
    if ($urandom_range(0, 5) == 0) len = top;
    return len;
  endfunction

  function automatic int pick_fill();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return -1;
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_in++;
  endtask

  task automatic send_header(input logic [31:0] len_word, input logic [31:0] sum_word,
                             input bit spoil, input int count);
    logic [95:0] hdr;
    int          k;
    hdr = {MAGIC_WORD, len_word, sum_word};
    if (spoil) begin
      k = $urandom_range(0, 3);
      hdr[95 - 8*k -: 8] = hdr[95 - 8*k -: 8] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < count; i++) send_beat(make_beat(KIND_BYTE, hdr[95 - 8*i -: 8]));
  endtask

  // cut: payload beats actually sent
  task automatic send_record(input int len, input int fill, input bit spoil_sum, input int cut);
    logic [7:0]  body[$];
    logic [31:0] h;
    logic [31:0] word;
    h = FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      body = {body, ((fill < 0) ? 8'($urandom) : 8'(fill))};
      h = (h ^ {24'h0, body[i]}) * FNV_PRIME;
    end
    word = spoil_sum ? (h ^ (32'h1 << $urandom_range(0, 31))) : h;
    send_header(32'(len), word, 1'b0, HDR_BYTES);
    for (int i = 0; i < cut; i++) send_beat(make_beat(KIND_BYTE, body[i]));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic pick_limit_reg();
    logic [LEN_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = LEN_W'(1);
      1:       v = LEN_W'($urandom_range(1, 64));
      2:       v = LEN_W'(REC_LEN_CAP);
      3:       v = '1;
      default: v = LEN_W'($urandom_range(1, REC_LEN_CAP));
    endcase
    write_reg(CFG_MAX_LEN, {10'($urandom), v});
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          rand_start;
    int          phase_no;
    int          n_rec;
    int          len;
    logic [31:0] bad_len;
    finale_t     fin;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_beat     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_MAX_LEN;
    cfg_wdata   = '0;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_req    = 1'b0;
    beats_in    = 0;
    cfg_writes  = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset limits, then a one-byte limit written with junk upper bits
    send_record(1, 8'hFF, 1'b0, 1);
    settle();
    write_reg(CFG_MAX_LEN, {10'h3FF, 14'd1});
    write_reg(CFG_CAPACITY, 24'hFF_FFFF);
    write_reg(CFG_SPARE_LO, 24'hFF_FFFF);
    write_reg(CFG_SPARE_HI, 24'h00_0000);
    send_record(1, 8'h00, 1'b0, 1);

    rand_start = beats_in;
    phase_no   = 0;
    while (beats_in - rand_start < RAND_BEATS) begin
      settle();
      phase_no++;
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      pick_limit_reg();
      n_rec = $urandom_range(1, 4);
      len   = pick_len();
      case ($urandom_range(0, 3))
        0: write_reg(CFG_CAPACITY, 24'hFF_FFFF);
        1: write_reg(CFG_CAPACITY, CAPACITY_RST);
        2: write_reg(CFG_CAPACITY, 24'($urandom_range(int'(sb.rec_off) + 600, 24'hFF_FFFF)));
        default: begin
          // record ends exactly on the capacity
          n_rec = 1;
          write_reg(CFG_CAPACITY, sb.rec_off + 24'(HDR_BYTES + len));
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
      if (phase_no == 2) begin
        // keep offering beats while the result side is held off
        write_reg(CFG_CAPACITY, 24'hFF_FFFF);
        in_idle_on = 1'b0;
        hold_req   = 1'b1;
        n_rec      = 4;
      end
      for (int r = 0; r < n_rec; r++) begin
        send_record(len, pick_fill(), 1'b0, len);
        len = pick_len();
      end
    end

    settle();
    write_reg(CFG_MAX_LEN, CFG_W'(REC_LEN_CAP));
    write_reg(CFG_CAPACITY, CAPACITY_RST);
    send_record(LONG_LEN, -1, 1'b0, LONG_LEN);

    settle();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    pick_limit_reg();
    write_reg(CFG_CAPACITY, 24'hFF_FFFF);
    repeat (4) begin
      len = pick_len();
      send_record(len, pick_fill(), 1'b0, len);
    end

    settle();
    fin = finale_t'($urandom_range(0, 7));
    case (fin)
      FIN_CLEAN: ;
      FIN_CUT_HEADER:
        send_header(32'(pick_len()), 32'($urandom), 1'b0, $urandom_range(1, HDR_BYTES - 1));
      FIN_CUT_PAYLOAD: begin
        len = pick_len();
        send_record(len, pick_fill(), 1'b0, $urandom_range(0, len - 1));
      end
      FIN_BAD_MAGIC: send_header(32'(pick_len()), 32'($urandom), 1'b1, HDR_BYTES);
      FIN_ZERO_LEN: send_header(32'h0, 32'($urandom), 1'b0, HDR_BYTES);
      FIN_LONG_LEN: begin
        case ($urandom_range(0, 3))
          0: bad_len = 32'(cur_limit() + 1);
          1: bad_len = 32'hFFFF_FFFF;
          2: bad_len = 32'h0001_0000 | 32'($urandom_range(1, cur_limit()));
          default: begin
            write_reg(CFG_MAX_LEN, {10'($urandom), 14'd0});
            bad_len = 32'($urandom_range(1, 48));
          end
        endcase
        send_header(bad_len, 32'($urandom), 1'b0, HDR_BYTES);
      end
      FIN_BAD_SUM: begin
        len = pick_len();
        send_record(len, pick_fill(), 1'b1, len);
      end
      default: begin
        len = pick_len();
        write_reg(CFG_CAPACITY, sb.rec_off + 24'(HDR_BYTES + len - 1));
        send_record(len, pick_fill(), 1'b0, len);
      end
    endcase
    if (fin == FIN_CLEAN || fin == FIN_CUT_HEADER || fin == FIN_CUT_PAYLOAD)
      send_beat(make_beat(KIND_EOS, 8'($urandom)));
    // halted: these beats must give nothing
    repeat (6) send_beat(make_beat(1'($urandom), 8'($urandom)));

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    sb.close();
    $display("Stream of %0d beats gave %0d checked results; %0d records accepted, longest %0d.",
             beats_in, sb.checked, sb.accepted, LONG_LEN);
    $display("%0d register writes; stream closed on %s, then halted beats were ignored.",
             cfg_writes, finale_name[fin]);
    if (sb.errors == 0) begin
      $display("journal_record_deframer_checker_core_tb: done, clean");
    end else begin
      $display("journal_record_deframer_checker_core_tb: done, errors");
    end
    $finish;
  end

endmodule
